[hw/rtl/b64e_pkg.sv]
// ----------------------------------------------------------------------------
// b64e_pkg
// shared types, constants and the base64 alphabet lookup for the encoder
// ----------------------------------------------------------------------------
package b64e_pkg;

  // default depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // six-bit symbol codes plus one extra code for the pad character
  localparam int unsigned CODE_W = 7;
  localparam logic [CODE_W-1:0] CODE_PAD = 7'd64;

  // most characters one byte can produce
  localparam int unsigned MAX_CHARS = 4;

  localparam logic [7:0] ASCII_PLUS  = 8'h2B;
  localparam logic [7:0] ASCII_SLASH = 8'h2F;
  localparam logic [7:0] ASCII_EQUAL = 8'h3D;

  // position of the next byte within its three-byte group
  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  // one classified byte: its characters in order, index of the final one,
  // and whether the final one closes the message
  typedef struct packed {
    logic [MAX_CHARS-1:0][CODE_W-1:0] codes;
    logic [1:0]                       last_idx;
    logic                             last;
  } entry_t;

  // symbol code to ascii
  function automatic logic [7:0] b64_char(input logic [CODE_W-1:0] code);
    logic [7:0] c;
    c = {1'b0, code};
    if (code[6]) begin
      return ASCII_EQUAL;
    end else if (code < 7'd26) begin
      return c + 8'h41;
    end else if (code < 7'd52) begin
      return c + 8'd71;
    end else if (code < 7'd62) begin
      return c - 8'd4;
    end else if (code == 7'd62) begin
      return ASCII_PLUS;
    end else begin
      return ASCII_SLASH;
    end
  endfunction

endpackage

[hw/rtl/b64e_byte_if.sv]
// ----------------------------------------------------------------------------
// b64e_byte_if
// raw byte channel: one message byte and its end-of-message flag per word
// ----------------------------------------------------------------------------
interface b64e_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

[hw/rtl/b64e_char_if.sv]
// ----------------------------------------------------------------------------
// b64e_char_if
// character channel: one base64 ascii character and its last flag per word
// ----------------------------------------------------------------------------
interface b64e_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       out_last;

  modport source (output valid, output out_char, output out_last, input ready);
  modport sink (input valid, input out_char, input out_last, output ready);
endinterface

[hw/rtl/b64e_front.sv]
// ----------------------------------------------------------------------------
// b64e_front
// accepts raw bytes, tracks the group phase and splits each byte into the
// symbol codes it produces
// ----------------------------------------------------------------------------
module b64e_front import b64e_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  b64e_byte_if.sink   bytes,
  input  logic        full,
  output logic        push,
  output entry_t      entry
);

  phase_t     phase;
  phase_t     phase_next;
  logic [3:0] leftover_bits;
  logic [3:0] leftover_bits_next;
  logic [7:0] b;
  logic       fin;

  assign b    = bytes.data_byte;
  assign fin  = bytes.final_byte;
  assign push = bytes.valid && !full;
  assign bytes.ready = !full;

  // next state
  always_comb begin
    phase_next         = PH_FIRST;
    leftover_bits_next = 4'd0;
    unique case (phase)
      PH_SECOND: begin
        if (!fin) begin
          phase_next         = PH_THIRD;
          leftover_bits_next = b[3:0];
        end
      end
      PH_THIRD: begin
        phase_next = PH_FIRST;
      end
      default: begin
        if (!fin) begin
          phase_next         = PH_SECOND;
          leftover_bits_next = {2'b00, b[1:0]};
        end
      end
    endcase
  end

  // classification
  always_comb begin
    entry.codes    = {MAX_CHARS{CODE_PAD}};
    entry.last_idx = 2'd0;
    entry.last     = fin;
    unique case (phase)
      PH_SECOND: begin
        entry.codes[0] = {1'b0, leftover_bits[1:0], b[7:4]};
        if (fin) begin
          entry.codes[1] = {1'b0, b[3:0], 2'b00};
          entry.last_idx = 2'd2;
        end
      end
      PH_THIRD: begin
        entry.codes[0] = {1'b0, leftover_bits, b[7:6]};
        entry.codes[1] = {1'b0, b[5:0]};
        entry.last_idx = 2'd1;
      end
      default: begin
        entry.codes[0] = {1'b0, b[7:2]};
        if (fin) begin
          entry.codes[1] = {1'b0, b[1:0], 4'b0000};
          entry.last_idx = 2'd3;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_FIRST;
      leftover_bits <= 4'd0;
    end else if (push) begin
      phase         <= phase_next;
      leftover_bits <= leftover_bits_next;
    end
  end

endmodule

[hw/rtl/b64e_queue.sv]
// ----------------------------------------------------------------------------
// b64e_queue
// small registered fifo of classified bytes between front and back
// ----------------------------------------------------------------------------
module b64e_queue import b64e_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  entry_t        slots [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == FULL_COUNT);
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/b64e_back.sv]
// ----------------------------------------------------------------------------
// b64e_back
// walks the characters of the head entry, one per cycle while chars is not
// stalled, into the output register
// ----------------------------------------------------------------------------
module b64e_back import b64e_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  entry_t      head,
  output logic        pop,
  b64e_char_if.source chars
);

  logic [1:0] idx;
  logic       load;
  logic       at_end;

  assign at_end = (idx == head.last_idx);
  assign load   = head_valid && (!chars.valid || chars.ready);
  assign pop    = load && at_end;

  always_ff @(posedge clk) begin
    if (load) begin
      chars.out_char <= b64_char(head.codes[idx]);
      chars.out_last <= head.last && at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chars.valid <= 1'b0;
      idx         <= 2'd0;
    end else begin
      if (load) begin
        chars.valid <= 1'b1;
        idx         <= at_end ? 2'd0 : idx + 2'd1;
      end else if (chars.ready) begin
        chars.valid <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/base64_stream_encoder.sv]
// ----------------------------------------------------------------------------
// base64_stream_encoder
// streaming base64 encoder, standard alphabet with '=' padding
// ----------------------------------------------------------------------------
// takes a message one raw byte per word on bytes, with final_byte set on the
// last byte, and gives base64 ascii characters one per word on chars, with
// out_last set on the last character of the message. a byte in group position
// one or two gives one character, position three gives two, and the final
// byte also flushes the leftover bits and pads with '=' to a multiple of four,
// so it gives up to four. bytes are taken one per cycle while the queue
// between front and back has room; the output side gives one character per
// cycle while chars is not stalled, so a steady stream runs at four
// characters per three bytes. apart from stalls on chars, the output
// register is the only thing limiting the rate. a taken byte is written into
// a queue slot, and its characters are loaded from there into the output
// register once it is at the head of the queue and the register is free.
// empty messages cannot be expressed.
// ----------------------------------------------------------------------------
module base64_stream_encoder import b64e_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  b64e_byte_if.sink   bytes,
  b64e_char_if.source chars
);

  // front to queue
  logic   push;
  entry_t push_entry;
  logic   full;

  // queue to back
  logic   pop;
  logic   head_valid;
  entry_t head;

  // classifier: phase and leftover bits live here
  b64e_front u_front (
    .clk   (clk),
    .rst   (rst),
    .bytes (bytes),
    .full  (full),
    .push  (push),
    .entry (push_entry)
  );

  // decoupling queue, lets the byte side run ahead of the character side
  b64e_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // character sequencer and output register
  b64e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .chars      (chars)
  );

endmodule

[hw/rtl/b64e_checker.sv]
// ----------------------------------------------------------------------------
// b64e_checker
// port-level checks on the character stream of the encoder
// ----------------------------------------------------------------------------
module b64e_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_last
);

  logic out_take;
  logic pad_pending;

  assign out_take = out_valid && out_ready;

  // a non-final '=' must be followed by another '='
  always_ff @(posedge clk) begin
    if (rst) begin
      pad_pending <= 1'b0;
    end else if (out_take) begin
      pad_pending <= (out_char == 8'h3D) && !out_last;
    end
  end

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("character word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_char) && $stable(out_last))
    else $error("character word changed while stalled");

  a_alphabet: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_char >= 8'h41 && out_char <= 8'h5A) ||
                  (out_char >= 8'h61 && out_char <= 8'h7A) ||
                  (out_char >= 8'h30 && out_char <= 8'h39) ||
                  out_char == 8'h2B || out_char == 8'h2F || out_char == 8'h3D)
    else $error("character outside base64 alphabet");

  a_pad_run: assert property (@(posedge clk) disable iff (rst)
    out_take && pad_pending |-> out_char == 8'h3D)
    else $error("padding broken before end of message");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("character word valid straight after reset");

endmodule

bind base64_stream_encoder b64e_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (chars.valid),
  .out_ready (chars.ready),
  .out_char  (chars.out_char),
  .out_last  (chars.out_last)
);
